@@ rtl/fpba_pkg.sv @@
package fpba_pkg;

  localparam int unsigned MAX_BLOCKS_DEF  = 16;
  localparam int unsigned SIZE_BITS_DEF   = 16;
  localparam int unsigned ENTRY_IDX_W     = 4;
  localparam int unsigned SIZE_FIELD_W    = 16;
  localparam int unsigned BLOCK_IDX_W     = 4;
  localparam int unsigned FIT_MODE_W      = 2;
  localparam int unsigned BLOCK_COUNT_W   = 5;
  localparam int unsigned CFG_IDX_W       = 1;
  localparam int unsigned CFG_DATA_W      = 5;

  typedef enum logic [FIT_MODE_W-1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2
  } fit_mode_e;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_ALLOC = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIT_MODE    = 1'b0,
    REG_BLOCK_COUNT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic                    command;
    logic [ENTRY_IDX_W-1:0]  entry_index;
    logic [SIZE_FIELD_W-1:0] size_value;
    logic                    end_of_run;
  } req_t;

  typedef struct packed {
    logic                   granted;
    logic [BLOCK_IDX_W-1:0] block_index;
  } res_t;

  typedef struct packed {
    logic valid;
    logic found;
  } probe_ctl_t;

  typedef struct packed {
    logic load;
    logic sub;
    logic restore;
  } cell_ctl_t;

endpackage

@@ rtl/fpba_cell.sv @@
module fpba_cell #(
  parameter int unsigned SizeBits = 16,
  parameter int unsigned IdxW     = 4,
  parameter int unsigned CellIdx  = 0
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_use_i,
  input  logic [fpba_pkg::FIT_MODE_W-1:0]  mode_i,
  input  fpba_pkg::cell_ctl_t              ctl_i,
  input  logic [fpba_pkg::ENTRY_IDX_W-1:0] load_idx_i,
  input  logic [IdxW-1:0]                  sub_idx_i,
  input  logic [SizeBits-1:0]              data_i,
  input  fpba_pkg::probe_ctl_t             probe_i,
  input  logic [IdxW-1:0]                  idx_i,
  input  logic [SizeBits-1:0]              best_i,
  input  logic [SizeBits-1:0]              want_i,
  output fpba_pkg::probe_ctl_t             probe_o,
  output logic [IdxW-1:0]                  idx_o,
  output logic [SizeBits-1:0]              best_o,
  output logic [SizeBits-1:0]              want_o
);
  import fpba_pkg::*;

  localparam int unsigned CmpW = ((IdxW > ENTRY_IDX_W) ? IdxW : ENTRY_IDX_W) + 1;

  logic [SizeBits-1:0] orig_q, rem_q;
  probe_ctl_t          probe_q, probe_d;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic [SizeBits-1:0] best_q, best_d, want_q;
  logic                fits, better, take, load_hit, sub_hit;

  always_comb begin
    fits = in_use_i && (rem_q >= want_i);
    case (mode_i)
      FIT_BEST:  better = rem_q < best_i;
      FIT_WORST: better = rem_q > best_i;
      default:   better = 1'b0;
    endcase
    take          = probe_i.valid && fits && (!probe_i.found || better);
    probe_d.valid = probe_i.valid;
    probe_d.found = probe_i.found | take;
    idx_d         = take ? IdxW'(CellIdx) : idx_i;
    best_d        = take ? rem_q : best_i;
  end

  assign load_hit = ctl_i.load && (CmpW'(load_idx_i) == CmpW'(CellIdx));
  assign sub_hit  = ctl_i.sub && (sub_idx_i == IdxW'(CellIdx));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_q <= '0;
    end else begin
      probe_q <= probe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    best_q <= best_d;
    want_q <= want_i;
    if (load_hit) begin
      orig_q <= data_i;
    end
    if (load_hit) begin
      rem_q <= data_i;
    end else if (ctl_i.restore) begin
      rem_q <= orig_q;
    end else if (sub_hit) begin
      rem_q <= rem_q - data_i;
    end
  end

  assign probe_o = probe_q;
  assign idx_o   = idx_q;
  assign best_o  = best_q;
  assign want_o  = want_q;

endmodule

@@ rtl/fit_policy_block_allocator.sv @@
// result: done_o and res_o are registered from the last cell of the row once the probe has
// passed through every cell register; res_o is valid while done_o is high; loads give no result
// issue: no new request is taken until busy_o is low again, as the probe walks the row of
// cells one entry per cycle; loads are taken whenever busy_o is low
// reset: clears control, fit mode to first fit and block count to one; table entries hold
// no value until loaded; results are never held off by the receiver
module fit_policy_block_allocator #(
  parameter int unsigned MAX_BLOCKS = fpba_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fpba_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fpba_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            start_i,
  input  fpba_pkg::req_t                  req_i,
  output logic                            busy_o,
  output logic                            done_o,
  output fpba_pkg::res_t                  res_o
);
  import fpba_pkg::*;

  localparam int unsigned IdxW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CmpW = ((IdxW > BLOCK_COUNT_W) ? IdxW : BLOCK_COUNT_W) + 1;

  logic [FIT_MODE_W-1:0]    fit_mode_q;
  logic [BLOCK_COUNT_W-1:0] block_count_q;
  logic                     busy_q, busy_d, eor_q, done_q;
  res_t                     res_q, res_d;

  probe_ctl_t          probe [MAX_BLOCKS+1];
  logic [IdxW-1:0]     pidx  [MAX_BLOCKS+1];
  logic [SIZE_BITS-1:0] pbest [MAX_BLOCKS+1];
  logic [SIZE_BITS-1:0] pwant [MAX_BLOCKS+1];

  logic                 accept, req_go, load_go, last;
  cell_ctl_t            ctl;
  logic [SIZE_BITS-1:0] data_bus;

  assign accept  = start_i && !busy_q;
  assign req_go  = accept && (req_i.command == CMD_ALLOC);
  assign load_go = accept && (req_i.command == CMD_LOAD);
  assign last    = probe[MAX_BLOCKS].valid;

  assign probe[0].valid = req_go;
  assign probe[0].found = 1'b0;
  assign pidx[0]        = '0;
  assign pbest[0]       = '0;
  assign pwant[0]       = SIZE_BITS'(req_i.size_value);

  always_comb begin
    ctl.load    = load_go;
    ctl.sub     = last && probe[MAX_BLOCKS].found;
    ctl.restore = last && eor_q;
    data_bus    = last ? pwant[MAX_BLOCKS] : SIZE_BITS'(req_i.size_value);
    busy_d      = busy_q;
    if (req_go) begin
      busy_d = 1'b1;
    end else if (last) begin
      busy_d = 1'b0;
    end
    res_d.granted     = probe[MAX_BLOCKS].found;
    res_d.block_index = probe[MAX_BLOCKS].found ? BLOCK_IDX_W'(pidx[MAX_BLOCKS]) : '0;
  end

  for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
    fpba_cell #(
      .SizeBits (SIZE_BITS),
      .IdxW     (IdxW),
      .CellIdx  (i)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .in_use_i   (CmpW'(block_count_q) > CmpW'(i)),
      .mode_i     (fit_mode_q),
      .ctl_i      (ctl),
      .load_idx_i (req_i.entry_index),
      .sub_idx_i  (pidx[MAX_BLOCKS]),
      .data_i     (data_bus),
      .probe_i    (probe[i]),
      .idx_i      (pidx[i]),
      .best_i     (pbest[i]),
      .want_i     (pwant[i]),
      .probe_o    (probe[i+1]),
      .idx_o      (pidx[i+1]),
      .best_o     (pbest[i+1]),
      .want_o     (pwant[i+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_mode_q    <= FIT_FIRST;
      block_count_q <= BLOCK_COUNT_W'(1);
      busy_q        <= 1'b0;
      done_q        <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_idx_i == REG_FIT_MODE)) begin
        fit_mode_q <= cfg_wdata_i[FIT_MODE_W-1:0];
      end
      if (cfg_we_i && (cfg_idx_i == REG_BLOCK_COUNT)) begin
        block_count_q <= cfg_wdata_i[BLOCK_COUNT_W-1:0];
      end
      busy_q <= busy_d;
      done_q <= last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_go) begin
      eor_q <= req_i.end_of_run;
    end
    if (last) begin
      res_q <= res_d;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

@@ rtl/fpba_checker.sv @@
module fpba_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            cfg_we_i,
  input logic [fpba_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input logic [fpba_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input logic                            start_i,
  input fpba_pkg::req_t                  req_i,
  input logic                            busy_o,
  input logic                            done_o,
  input fpba_pkg::res_t                  res_o
);
  import fpba_pkg::*;

  a_alloc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (req_i.command == CMD_ALLOC) |=> busy_o)
    else $error("request taken without going busy");

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (req_i.command == CMD_LOAD) |=> !busy_o && !done_o)
    else $error("load caused activity");

  a_done_on_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o)
    else $error("busy dropped without a result");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_no_grant_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !res_o.granted |-> (res_o.block_index == '0))
    else $error("index set on a refused request");

endmodule

bind fit_policy_block_allocator fpba_checker u_fpba_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_we_i    (cfg_we_i),
  .cfg_idx_i   (cfg_idx_i),
  .cfg_wdata_i (cfg_wdata_i),
  .start_i     (start_i),
  .req_i       (req_i),
  .busy_o      (busy_o),
  .done_o      (done_o),
  .res_o       (res_o)
);
